@@ hw/rtl/lsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and constants for the LSB pixel extractor
// Channel lane result type, channel count and character limits.
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int NUM_LANES   = 3;   // red, green, blue
   localparam int COMP_W      = 8;   // width of one pixel component
   localparam int MAX_BITS    = 7;   // most data bits a channel carries
   localparam int LEN_W       = 3;   // width of a per-channel bit count
   localparam int PRINT_FLOOR = 31;  // characters at or below this are dropped
   localparam int OUT_CHAR_W  = 7;   // width of an emitted character
   localparam int MAX_CANDS   = 5;   // candidate character slots checked per pixel
   localparam int MAX_RESULTS = 3;   // most characters one pixel may emit

   typedef logic [LEN_W-1:0] len_type;

   // What one channel lane hands to the merge stage
   typedef struct packed {
      logic [MAX_BITS-1:0] bits;  // data bits, right aligned, above len cleared
      len_type             len;   // number of data bits in this pixel
      len_type             sat;   // component saturated for a header pixel
   } lane_type;

endpackage

@@ hw/rtl/lsb_stego_pixel_extractor.sv @@
// ----------------------------------------------------------------------------
// lsb_stego_pixel_extractor: recovers hidden characters from pixel LSBs
// Three channel lanes feed a merge stage; an output buffer sends characters.
// ----------------------------------------------------------------------------
// Latency: a character beat is offered the cycle after its pixel is accepted.
// Throughput: one pixel per cycle when it yields no character; otherwise a
//   pixel holds the input until the single-beat result channel has drained
//   the character buffer of the characters it emits (1 to 3).
// Reset: synchronous, active high; the next pixel is a header, per-channel bit
//   counts, accumulator and character buffer are cleared.
module lsb_stego_pixel_extractor
   import lsp_pkg::*;
#(
   parameter int CHAR_WIDTH = 7
)
(
   input  logic        clock,
   input  logic        reset,
   // input pixel beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic        req_tuser,   // frame_start [0]
   // character beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // character [6:0], zero pad [7]
   output logic        rsp_tlast    // last character of this pixel
);

   localparam int ACC_W = CHAR_WIDTH - 1;
   localparam int CNT_W = $clog2(CHAR_WIDTH);
   localparam int SEL_W = $clog2(MAX_CANDS);

   // channel configuration from the header pixel
   logic                       hdr_ff,  hdr_in;
   len_type [NUM_LANES-1:0]    width_ff, width_in;
   // bit accumulator
   logic [ACC_W-1:0]           acc_ff,  acc_in;
   logic [CNT_W-1:0]           cnt_ff,  cnt_in;
   // character buffer: one slot per candidate, emitted lowest slot first
   logic [MAX_CANDS-1:0]       vld_ff,  vld_in;
   logic [MAX_CANDS-1:0][OUT_CHAR_W-1:0] chr_ff, chr_in;

   lane_type [NUM_LANES-1:0]                lane;
   logic [MAX_CANDS-1:0][CHAR_WIDTH-1:0]    cand;
   logic [MAX_CANDS-1:0]                    cand_ok;
   logic [MAX_CANDS-1:0]                    keep;
   logic [ACC_W-1:0]                        acc_nxt;
   logic [CNT_W-1:0]                        cnt_nxt;
   logic [SEL_W-1:0]                        sel;
   logic [MAX_CANDS-1:0]                    sel_onehot;
   logic                                    single;
   logic                                    req_fire;
   logic                                    rsp_fire;
   logic                                    is_header;
   int unsigned                             kept;

   // one lane per color channel, all working on the same pixel
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      lsp_lane u_lane (
         .comp_i (req_tdata[g*COMP_W +: COMP_W]),
         .len_i  (width_ff[g]),
         .lane_o (lane[g])
      );
   end

   lsp_merge #(.CHAR_WIDTH(CHAR_WIDTH)) u_merge (
      .acc_i     (acc_ff),
      .cnt_i     (cnt_ff),
      .lane_i    (lane),
      .cand_o    (cand),
      .cand_ok_o (cand_ok),
      .acc_o     (acc_nxt),
      .cnt_o     (cnt_nxt)
   );

   // pick the oldest pending character; it is the last one if none follow it
   always_comb begin
      sel = '0;
      for (int k = MAX_CANDS - 1; k >= 0; k--) begin
         if (vld_ff[k]) begin
            sel = SEL_W'(k);
         end
      end
      sel_onehot = MAX_CANDS'(1) << sel;
      single     = (vld_ff & (vld_ff - MAX_CANDS'(1))) == '0;
   end

   assign rsp_tvalid = |vld_ff;
   assign rsp_tdata  = {1'b0, chr_ff[sel]};
   assign rsp_tlast  = single;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // take a new pixel once the buffer drains, including the cycle its last
   // character leaves
   assign req_tready = !rsp_tvalid || (rsp_tready && single);
   assign req_fire   = req_tvalid && req_tready;
   assign is_header  = req_tuser || hdr_ff;

   always_comb begin
      // keep only the first few printable characters of a pixel
      kept = 0;
      for (int k = 0; k < MAX_CANDS; k++) begin
         keep[k]   = cand_ok[k] && (kept < MAX_RESULTS);
         kept      = kept + (cand_ok[k] ? 1 : 0);
         chr_in[k] = OUT_CHAR_W'(cand[k]);
      end

      hdr_in   = hdr_ff;
      width_in = width_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      vld_in   = vld_ff;

      if (rsp_fire) begin
         vld_in = vld_ff & ~sel_onehot;
      end

      if (req_fire) begin
         if (is_header) begin
            // header: load bit counts, clear the accumulator, emit nothing
            hdr_in = 1'b0;
            for (int i = 0; i < NUM_LANES; i++) begin
               width_in[i] = lane[i].sat;
            end
            acc_in = '0;
            cnt_in = '0;
            vld_in = '0;
         end else begin
            acc_in = acc_nxt;
            cnt_in = cnt_nxt;
            vld_in = keep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff   <= 1'b1;
         width_ff <= '0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         vld_ff   <= '0;
      end else begin
         hdr_ff   <= hdr_in;
         width_ff <= width_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

   // character payload: load only with a new pixel
   always_ff @(posedge clock) begin
      if (req_fire) begin
         chr_ff <= chr_in;
      end
   end

endmodule

@@ hw/rtl/lsp_lane.sv @@
// ----------------------------------------------------------------------------
// lsp_lane: one color channel lane
// Masks the low data bits of a component and saturates header values.
// ----------------------------------------------------------------------------
module lsp_lane
   import lsp_pkg::*;
(
   input  logic [COMP_W-1:0] comp_i,
   input  len_type           len_i,
   output lane_type          lane_o
);

   logic [COMP_W-1:0] mask;

   always_comb begin
      mask         = (COMP_W'(1) << len_i) - COMP_W'(1);
      lane_o.bits  = MAX_BITS'(comp_i & mask);
      lane_o.len   = len_i;
      lane_o.sat   = (comp_i > COMP_W'(MAX_BITS)) ? LEN_W'(MAX_BITS) : comp_i[LEN_W-1:0];
   end

endmodule

@@ hw/rtl/lsp_merge.sv @@
// ----------------------------------------------------------------------------
// lsp_merge: joins lane bits onto the accumulator and cuts characters
// Flags every completed character above the printable floor.
// ----------------------------------------------------------------------------
module lsp_merge
   import lsp_pkg::*;
#(
   parameter int CHAR_WIDTH = 7
)
(
   input  logic [CHAR_WIDTH-2:0]                  acc_i,
   input  logic [$clog2(CHAR_WIDTH)-1:0]          cnt_i,
   input  lane_type [NUM_LANES-1:0]               lane_i,
   output logic [MAX_CANDS-1:0][CHAR_WIDTH-1:0]   cand_o,
   output logic [MAX_CANDS-1:0]                   cand_ok_o,
   output logic [CHAR_WIDTH-2:0]                  acc_o,
   output logic [$clog2(CHAR_WIDTH)-1:0]          cnt_o
);

   localparam int ACC_W  = CHAR_WIDTH - 1;
   localparam int CNT_W  = $clog2(CHAR_WIDTH);
   localparam int PACK_W = ACC_W + NUM_LANES * MAX_BITS;
   localparam int TOT_W  = $clog2(PACK_W + 1);

   logic [PACK_W-1:0]    packed_bits;
   logic [TOT_W-1:0]     total;
   logic [TOT_W-1:0]     rem;
   logic [TOT_W-1:0]     shift;
   logic [MAX_CANDS-1:0] done;

   always_comb begin
      // oldest bits end up most significant
      packed_bits = PACK_W'(acc_i);
      total       = TOT_W'(cnt_i);
      for (int i = 0; i < NUM_LANES; i++) begin
         packed_bits = (packed_bits << lane_i[i].len) | PACK_W'(lane_i[i].bits);
         total       = total + TOT_W'(lane_i[i].len);
      end

      rem = total;
      for (int k = 0; k < MAX_CANDS; k++) begin
         done[k]      = int'(total) >= (k + 1) * CHAR_WIDTH;
         shift        = TOT_W'(int'(total) - (k + 1) * CHAR_WIDTH);
         cand_o[k]    = CHAR_WIDTH'(packed_bits >> shift);
         cand_ok_o[k] = done[k] && (int'(cand_o[k]) > PRINT_FLOOR);
         if (done[k]) begin
            rem = shift;
         end
      end

      acc_o = ACC_W'(packed_bits & ((PACK_W'(1) << rem) - PACK_W'(1)));
      cnt_o = CNT_W'(rem);
   end

endmodule

@@ hw/rtl/lsp_checker.sv @@
// ----------------------------------------------------------------------------
// lsp_checker: port-level checks for the LSB pixel extractor
// Watches the handshakes and character beats over time.
// ----------------------------------------------------------------------------
module lsp_checker #(
   parameter int CHAR_WIDTH = 7
)
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   // hold a stalled character beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled character beat changed");

   // buffer empties after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("character beat right after reset");

   // a header pixel emits nothing and leaves the buffer empty
   a_header_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !rsp_tvalid)
      else $error("character beat after a header pixel");

   // no new pixel while a character waits on a stalled sink
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("pixel accepted over a stalled character");

   // emitted characters are printable
   a_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[7] && ((CHAR_WIDTH > 7) || (rsp_tdata[6:5] != 2'b00)))
      else $error("non-printable character emitted");

endmodule

bind lsb_stego_pixel_extractor lsp_checker #(.CHAR_WIDTH(CHAR_WIDTH)) u_lsp_checker (.*);
